// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge out of reset.
`define ASSERT_CHECK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bdc_pkg.sv =====
// ---------------------------------------------------------------------------
// bdc_pkg
// Types, character codes and color table for the bracket depth classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

    localparam int POS_BITS    = 20;   // width of the character counter
    localparam int COLOR_BASE  = 0;
    localparam int COLOR_LIMIT = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;

    localparam logic [7:0] DEPTH_MAX = 8'hFF;

    typedef logic [255:0][7:0] color_table_t;

    function automatic color_table_t build_color_table();
        color_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'((COLOR_BASE + i) % COLOR_LIMIT);
        end
        return t;
    endfunction

    localparam color_table_t COLOR_TABLE = build_color_table();

    // One queued command: the per-character result plus the unclosed-kind tail
    typedef struct packed {
        logic [19:0]       position;
        logic              is_bracket;
        logic [1:0]        bracket_kind;
        logic              is_open;
        logic signed [8:0] nest_depth;
        logic              is_valid;
        logic [7:0]        color_index;
        logic [2:0]        tail_mask;   // bit per kind still open at end of text
        logic [2:0][19:0]  tail_pos;    // first offset of each kind
    } cmd_t;

    typedef struct packed {
        logic              record_kind;
        logic [19:0]       position;
        logic              is_bracket;
        logic [1:0]        bracket_kind;
        logic              is_open;
        logic signed [8:0] nest_depth;
        logic              is_valid;
        logic [7:0]        color_index;
        logic              run_end;
    } result_t;

    typedef enum logic [1:0] {
        PH_CHAR = 2'b01,
        PH_TAIL = 2'b10
    } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdc_front.sv =====
// ---------------------------------------------------------------------------
// bdc_front
// Classifies each byte, tracks per-kind depth and builds queue commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bdc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    input  wire logic          queue_full,
    output logic               push,
    output bdc_pkg::cmd_t      push_data
);

    logic [7:0]                   depth_reg [3];
    logic [7:0]                   depth_next [3];
    logic [2:0][19:0]             first_reg;
    logic [2:0][19:0]             first_next;
    logic [2:0]                   seen_reg;
    logic [2:0]                   seen_next;
    logic [bdc_pkg::POS_BITS-1:0] count_reg;
    logic [bdc_pkg::POS_BITS-1:0] count_next;

    logic              is_br;
    logic              is_op;
    logic [1:0]        kind;
    logic [7:0]        d_cur;
    logic signed [8:0] rep;
    logic              valid;
    logic [19:0]       pos;
    logic [2:0]        mask;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign pos      = 20'(count_reg);

    always_comb
    begin
        is_br = 1'b1;
        is_op = 1'b0;
        kind  = bdc_pkg::KIND_ROUND;
        case (in_byte)
            bdc_pkg::CH_LPAREN:  begin kind = bdc_pkg::KIND_ROUND;  is_op = 1'b1; end
            bdc_pkg::CH_RPAREN:  begin kind = bdc_pkg::KIND_ROUND;  end
            bdc_pkg::CH_LSQUARE: begin kind = bdc_pkg::KIND_SQUARE; is_op = 1'b1; end
            bdc_pkg::CH_RSQUARE: begin kind = bdc_pkg::KIND_SQUARE; end
            bdc_pkg::CH_LCURLY:  begin kind = bdc_pkg::KIND_CURLY;  is_op = 1'b1; end
            bdc_pkg::CH_RCURLY:  begin kind = bdc_pkg::KIND_CURLY;  end
            default:             begin is_br = 1'b0; end
        endcase
    end

    always_comb
    begin
        depth_next = depth_reg;
        first_next = first_reg;
        seen_next  = seen_reg;
        d_cur      = depth_reg[kind];
        rep        = '0;
        valid      = 1'b1;

        if (is_br)
        begin
            if (!seen_reg[kind])
            begin
                seen_next[kind]  = 1'b1;
                first_next[kind] = pos;
            end
            if (is_op)
            begin
                rep = signed'({1'b0, d_cur});
                if (d_cur != bdc_pkg::DEPTH_MAX)
                begin
                    depth_next[kind] = d_cur + 8'd1;
                end
            end
            else if (d_cur == 8'd0)
            begin
                rep   = -9'sd1;
                valid = 1'b0;
            end
            else
            begin
                depth_next[kind] = d_cur - 8'd1;
                rep              = signed'({1'b0, d_cur - 8'd1});
            end
        end

        for (int k = 0; k < 3; k++)
        begin
            mask[k] = in_last && (depth_next[k] != 8'd0);
        end

        push_data.position     = pos;
        push_data.is_bracket   = is_br;
        push_data.bracket_kind = is_br ? kind : bdc_pkg::KIND_ROUND;
        push_data.is_open      = is_br && is_op;
        push_data.nest_depth   = rep;
        push_data.is_valid     = valid;
        push_data.color_index  = (is_br && valid) ? bdc_pkg::COLOR_TABLE[rep[7:0]] : 8'd0;
        push_data.tail_mask    = mask;
        push_data.tail_pos     = first_next;

        count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                depth_reg[k] <= '0;
            end
            first_reg <= '0;
            seen_reg  <= '0;
            count_reg <= '0;
        end
        else if (push)
        begin
            if (in_last)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    depth_reg[k] <= '0;
                end
                first_reg <= '0;
                seen_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                depth_reg <= depth_next;
                first_reg <= first_next;
                seen_reg  <= seen_next;
                count_reg <= count_next;
            end
        end
    end

    `ASSERT_NEXT(a_text_end_clears, clk, rst_n, push && in_last, (count_reg == '0) && (seen_reg == '0), "state not cleared after end of text")

endmodule

`default_nettype wire

// ===== hw/rtl/bdc_queue.sv =====
// ---------------------------------------------------------------------------
// bdc_queue
// Short command queue between the classifier and the result sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bdc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bdc_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output bdc_pkg::cmd_t      pop_data,
    output logic               empty
);

    bdc_pkg::cmd_t                 slot_reg [bdc_pkg::QUEUE_DEPTH];
    logic [bdc_pkg::QUEUE_AW-1:0]  wr_reg;
    logic [bdc_pkg::QUEUE_AW-1:0]  wr_next;
    logic [bdc_pkg::QUEUE_AW-1:0]  rd_reg;
    logic [bdc_pkg::QUEUE_AW-1:0]  rd_next;
    logic [bdc_pkg::QUEUE_CW-1:0]  count_reg;
    logic [bdc_pkg::QUEUE_CW-1:0]  count_next;

    localparam logic [bdc_pkg::QUEUE_AW-1:0] LAST_SLOT = bdc_pkg::QUEUE_AW'(bdc_pkg::QUEUE_DEPTH - 1);
    localparam logic [bdc_pkg::QUEUE_CW-1:0] FULL_COUNT = bdc_pkg::QUEUE_CW'(bdc_pkg::QUEUE_DEPTH);

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_reg];

    always_comb
    begin
        wr_next    = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
        rd_next    = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_next;
            end
            if (pop)
            begin
                rd_reg <= rd_next;
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_CHECK(a_count_bound, clk, rst_n, count_reg <= FULL_COUNT, "queue count beyond depth")

endmodule

`default_nettype wire

// ===== hw/rtl/bdc_back.sv =====
// ---------------------------------------------------------------------------
// bdc_back
// Expands queued commands into result transactions into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bdc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bdc_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bdc_pkg::result_t   out_data
);

    bdc_pkg::phase_t  phase_reg;
    bdc_pkg::phase_t  phase_next;
    logic [2:0]       rem_reg;
    logic [2:0]       rem_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    bdc_pkg::result_t out_data_reg;
    bdc_pkg::result_t out_data_next;

    logic       can_load;
    logic [1:0] pick_kind;
    logic [2:0] pick_mask;
    logic [2:0] rem_left;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign can_load  = !out_valid_reg || out_ready;

    // tail order: curly, round, square
    always_comb
    begin
        if (rem_reg[bdc_pkg::KIND_CURLY])
        begin
            pick_kind = bdc_pkg::KIND_CURLY;
            pick_mask = 3'b100;
        end
        else if (rem_reg[bdc_pkg::KIND_ROUND])
        begin
            pick_kind = bdc_pkg::KIND_ROUND;
            pick_mask = 3'b001;
        end
        else
        begin
            pick_kind = bdc_pkg::KIND_SQUARE;
            pick_mask = 3'b010;
        end
        rem_left = rem_reg & ~pick_mask;
    end

    always_comb
    begin
        pop            = 1'b0;
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (can_load && !empty)
        begin
            out_valid_next = 1'b1;
            case (phase_reg)
                bdc_pkg::PH_CHAR:
                begin
                    out_data_next.record_kind  = 1'b0;
                    out_data_next.position     = head.position;
                    out_data_next.is_bracket   = head.is_bracket;
                    out_data_next.bracket_kind = head.bracket_kind;
                    out_data_next.is_open      = head.is_open;
                    out_data_next.nest_depth   = head.nest_depth;
                    out_data_next.is_valid     = head.is_valid;
                    out_data_next.color_index  = head.color_index;
                    out_data_next.run_end      = (head.tail_mask == 3'b000);
                    if (head.tail_mask == 3'b000)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        phase_next = bdc_pkg::PH_TAIL;
                        rem_next   = head.tail_mask;
                    end
                end
                bdc_pkg::PH_TAIL:
                begin
                    out_data_next.record_kind  = 1'b1;
                    out_data_next.position     = head.tail_pos[pick_kind];
                    out_data_next.is_bracket   = 1'b1;
                    out_data_next.bracket_kind = pick_kind;
                    out_data_next.is_open      = 1'b0;
                    out_data_next.nest_depth   = '0;
                    out_data_next.is_valid     = 1'b0;
                    out_data_next.color_index  = 8'd0;
                    out_data_next.run_end      = (rem_left == 3'b000);
                    rem_next                   = rem_left;
                    if (rem_left == 3'b000)
                    begin
                        pop        = 1'b1;
                        phase_next = bdc_pkg::PH_CHAR;
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !out_ready;
                    phase_next     = bdc_pkg::PH_CHAR;
                    rem_next       = 3'b000;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bdc_pkg::PH_CHAR;
            rem_reg       <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `ASSERT_CHECK(a_tail_has_work, clk, rst_n, (phase_reg != bdc_pkg::PH_TAIL) || (rem_reg != 3'b000), "tail phase with no kinds left")
    `ASSERT_CHECK(a_pop_nonempty, clk, rst_n, !pop || !empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== hw/rtl/bracket_depth_classifier.sv =====
// Bracket depth classifier: one text byte in per transaction on the slave
// stream (tdata = character, tlast = last character of the text), one or
// more result transactions out on the master stream. Each character gives
// one result (tuser = 0) with its offset, bracket kind, open/close flag,
// nesting depth, validity and color index. The last character is followed
// by one late mark (tuser = 1) per bracket kind left open, curly first,
// then round, then square; master tlast flags the last result of a byte.
// Throughput: one byte per cycle while the queue has room; a final byte
// gives one to four results, which the sequencer sends one at a time.
// The classifier and the sequencer are separated by a four-entry command
// queue, and the result sits in an output register, so input keeps flowing
// while a result waits. When the receiver stalls, the output register
// holds, the queue fills, and s_axis_tready drops once the queue is full.
// Reset (rst_n low) clears depths, first-offsets, the character counter,
// the queue and the output valid; the next byte starts a fresh text.
// ---------------------------------------------------------------------------
// bracket_depth_classifier
// Top level: stream ports, classifier, command queue and result sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bracket_depth_classifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [19:0] position, [20] is_bracket, [22:21] bracket_kind, [23] is_open,
    // [32:24] nest_depth, [33] is_valid, [41:34] color_index, [47:42] zero
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tuser,   // record_kind
    output logic             m_axis_tlast    // run_end
);

    // classifier to queue
    logic          push;
    bdc_pkg::cmd_t push_data;
    logic          queue_full;

    // queue to sequencer
    logic          pop;
    bdc_pkg::cmd_t head;
    logic          queue_empty;

    bdc_pkg::result_t res;

    bdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    bdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (queue_empty)
    );

    bdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    // pack result fields, position in the lowest bits
    assign m_axis_tdata = {6'd0,
                           res.color_index,
                           res.is_valid,
                           res.nest_depth,
                           res.is_open,
                           res.bracket_kind,
                           res.is_bracket,
                           res.position};
    assign m_axis_tuser = res.record_kind;
    assign m_axis_tlast = res.run_end;

endmodule

`default_nettype wire

// ===== bench/bdc_result_checker.sv =====
// ---------------------------------------------------------------------------
// bdc_result_checker
// Watches both streams of the bracket depth classifier, predicts the
// results of every accepted character and compares each result transaction
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdc_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          error_count,
    output int          pending_count,
    output int          char_count,
    output int          result_count,
    output int          late_mark_count
);

    // predictor state, one entry per bracket kind
    logic [7:0]  open_depth [3];
    logic [19:0] first_pos [3];
    logic        kind_seen [3];
    logic [19:0] char_pos;

    bdc_pkg::result_t expected_results [$];
    bdc_pkg::result_t oldest;

    task automatic clear_text_state();
        for (int i = 0; i < 3; i++)
        begin
            open_depth[i] = '0;
            first_pos[i]  = '0;
            kind_seen[i]  = 1'b0;
        end
        char_pos = '0;
    endtask

    task automatic classify_char(input logic [7:0] ch, input logic is_last);
        bdc_pkg::result_t r;
        logic [1:0]       kind;
        logic             hit;
        logic             opens;
        int               d;
        logic [1:0]       tail_order [3];
        begin
            tail_order[0] = bdc_pkg::KIND_CURLY;
            tail_order[1] = bdc_pkg::KIND_ROUND;
            tail_order[2] = bdc_pkg::KIND_SQUARE;
            hit   = 1'b1;
            opens = 1'b0;
            kind  = bdc_pkg::KIND_ROUND;
            case (ch)
                bdc_pkg::CH_LPAREN:  begin kind = bdc_pkg::KIND_ROUND;  opens = 1'b1; end
                bdc_pkg::CH_RPAREN:  kind = bdc_pkg::KIND_ROUND;
                bdc_pkg::CH_LSQUARE: begin kind = bdc_pkg::KIND_SQUARE; opens = 1'b1; end
                bdc_pkg::CH_RSQUARE: kind = bdc_pkg::KIND_SQUARE;
                bdc_pkg::CH_LCURLY:  begin kind = bdc_pkg::KIND_CURLY;  opens = 1'b1; end
                bdc_pkg::CH_RCURLY:  kind = bdc_pkg::KIND_CURLY;
                default:             hit = 1'b0;
            endcase

            r = '0;
            r.position = char_pos;
            r.is_valid = 1'b1;
            if (hit)
            begin
                if (!kind_seen[kind])
                begin
                    kind_seen[kind] = 1'b1;
                    first_pos[kind] = char_pos;
                end
                r.is_bracket   = 1'b1;
                r.bracket_kind = kind;
                r.is_open      = opens;
                if (opens)
                begin
                    // open reports depth before the increment, saturating
                    d = open_depth[kind];
                    if (open_depth[kind] != bdc_pkg::DEPTH_MAX)
                        open_depth[kind] = open_depth[kind] + 8'd1;
                end
                else if (open_depth[kind] == 8'd0)
                begin
                    // unmatched close
                    d = -1;
                    r.is_valid = 1'b0;
                end
                else
                begin
                    open_depth[kind] = open_depth[kind] - 8'd1;
                    d = open_depth[kind];
                end
                r.nest_depth  = d[8:0];
                r.color_index = r.is_valid
                    ? 8'((bdc_pkg::COLOR_BASE + d) % bdc_pkg::COLOR_LIMIT) : 8'd0;
            end
            expected_results.push_back(r);
            char_pos = char_pos + 20'd1;

            if (is_last)
            begin
                // late marks for every kind left open, curly first
                for (int i = 0; i < 3; i++)
                begin
                    if (open_depth[tail_order[i]] != 8'd0)
                    begin
                        r = '0;
                        r.record_kind  = 1'b1;
                        r.position     = first_pos[tail_order[i]];
                        r.is_bracket   = 1'b1;
                        r.bracket_kind = tail_order[i];
                        expected_results.push_back(r);
                        late_mark_count++;
                    end
                end
                clear_text_state();
            end
            expected_results[expected_results.size() - 1].run_end = 1'b1;
        end
    endtask

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_text_state();
            expected_results.delete();
            error_count     = 0;
            pending_count   = 0;
            char_count      = 0;
            result_count    = 0;
            late_mark_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                classify_char(s_axis_tdata, s_axis_tlast);
                char_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: result with nothing expected, expected none, got %h/%b/%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("record_kind", oldest.record_kind, m_axis_tuser);
                    check_field("position", oldest.position, m_axis_tdata[19:0]);
                    check_field("is_bracket", oldest.is_bracket, m_axis_tdata[20]);
                    check_field("bracket_kind", oldest.bracket_kind, m_axis_tdata[22:21]);
                    check_field("is_open", oldest.is_open, m_axis_tdata[23]);
                    check_field("nest_depth", $signed(oldest.nest_depth),
                                $signed(m_axis_tdata[32:24]));
                    check_field("is_valid", oldest.is_valid, m_axis_tdata[33]);
                    check_field("color_index", oldest.color_index, m_axis_tdata[41:34]);
                    check_field("tdata padding", 0, m_axis_tdata[47:42]);
                    check_field("run_end", oldest.run_end, m_axis_tlast);
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== bench/bracket_depth_classifier_tb.sv =====
// ---------------------------------------------------------------------------
// bracket_depth_classifier_tb
// Streams texts into the bracket depth classifier and lets the result
// checker predict and compare every result. Directed characters first,
// then one text sent flat out on both sides, and random texts, mostly
// properly nested, with random gaps on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_depth_classifier_tb;

    // whole-run limit, far above the slowest correct run
    localparam int RUN_LIMIT_NS = 100_000 * 20;
    localparam int RANDOM_CHARS = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // gaps on the sender and stalls on the receiver, switched off for the
    // gap-free text
    bit          idle_en = 1'b1;

    int          error_count;
    int          pending_count;
    int          char_count;
    int          result_count;
    int          late_mark_count;
    int          text_count;

    // the text being sent, last entry carries tlast
    logic [7:0]  text_q [$];

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bracket_depth_classifier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bdc_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .error_count     (error_count),
        .pending_count   (pending_count),
        .char_count      (char_count),
        .result_count    (result_count),
        .late_mark_count (late_mark_count)
    );

    // Receiver: ready drops about 12 percent of the time while idling is on.
    // Changes on the falling edge so the block samples it cleanly.
    always @(negedge clk)
    begin
        m_axis_tready <= !idle_en || ($urandom_range(0, 99) >= 12);
    end

    function automatic logic [7:0] open_char(input logic [1:0] kind);
        case (kind)
            bdc_pkg::KIND_ROUND:  return bdc_pkg::CH_LPAREN;
            bdc_pkg::KIND_SQUARE: return bdc_pkg::CH_LSQUARE;
            default:              return bdc_pkg::CH_LCURLY;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input logic [1:0] kind);
        case (kind)
            bdc_pkg::KIND_ROUND:  return bdc_pkg::CH_RPAREN;
            bdc_pkg::KIND_SQUARE: return bdc_pkg::CH_RSQUARE;
            default:              return bdc_pkg::CH_RCURLY;
        endcase
    endfunction

    // One slave transaction. Entered and left right after a falling edge;
    // tvalid is only lowered in a step of its own, never dropped and raised
    // in the same step.
    task automatic send_char(input logic [7:0] ch, input logic is_last);
        while (idle_en && $urandom_range(0, 99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
        text_count++;
    endtask

    // Mostly well-nested text: closes match the innermost open, other
    // characters are random bytes. Half the texts close everything at the
    // end, the rest leave kinds open to get late marks.
    task automatic build_nested_text(input int len);
        logic [1:0] nest_q [$];
        logic [1:0] kind;
        int         pick;
        begin
            text_q.delete();
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (nest_q.size() != 0 && pick < 30)
                begin
                    kind = nest_q.pop_back();
                    text_q.push_back(close_char(kind));
                end
                else if (pick < 60 && nest_q.size() < 200)
                begin
                    kind = 2'($urandom_range(bdc_pkg::KIND_ROUND, bdc_pkg::KIND_CURLY));
                    nest_q.push_back(kind);
                    text_q.push_back(open_char(kind));
                end
                else
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1))
            begin
                while (nest_q.size() != 0)
                    text_q.push_back(close_char(nest_q.pop_back()));
            end
        end
    endtask

    // Noise: brackets of any kind and direction, no nesting discipline.
    task automatic build_scrambled_text(input int len);
        logic [1:0] kind;
        begin
            text_q.delete();
            for (int i = 0; i < len; i++)
            begin
                kind = 2'($urandom_range(bdc_pkg::KIND_ROUND, bdc_pkg::KIND_CURLY));
                if ($urandom_range(0, 1))
                    text_q.push_back($urandom_range(0, 1) ? open_char(kind) : close_char(kind));
                else
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        logic [7:0] dir_ch [24];
        bit         dir_last [24];
        int         random_chars;

        // Directed characters. Offsets restart after each tlast.
        dir_ch = '{8'h00, bdc_pkg::CH_RPAREN, bdc_pkg::CH_LPAREN, bdc_pkg::CH_LSQUARE,
                   bdc_pkg::CH_LCURLY, 8'h41,
                   bdc_pkg::CH_LPAREN, bdc_pkg::CH_RPAREN, bdc_pkg::CH_RPAREN,
                   bdc_pkg::CH_RSQUARE, bdc_pkg::CH_RSQUARE, bdc_pkg::CH_RCURLY,
                   8'hFF, bdc_pkg::CH_LCURLY, bdc_pkg::CH_LPAREN, bdc_pkg::CH_LSQUARE, 8'h7E,
                   bdc_pkg::CH_RCURLY,
                   bdc_pkg::CH_LSQUARE,
                   bdc_pkg::CH_LPAREN, bdc_pkg::CH_RPAREN,
                   8'h5C, bdc_pkg::CH_LCURLY, bdc_pkg::CH_LPAREN};
        // close at zero, each open, balanced closes, then all three kinds
        // left open at the end (four results from one byte), a lone close
        // as a whole text, one kind left open, a balanced pair, two open
        dir_last = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     0, 0, 0, 0, 1,
                     1,
                     1,
                     0, 1,
                     0, 0, 1};

        text_count = 0;

        // hold reset, then release it on a falling edge
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 24; i++)
        begin
            send_char(dir_ch[i], dir_last[i]);
            if (dir_last[i])
                text_count++;
        end

        // One text flat out on both sides: back-to-back transactions.
        idle_en = 1'b0;
        build_nested_text(30);
        send_text();
        idle_en = 1'b1;

        // Random texts, four in five well nested.
        random_chars = 0;
        while (random_chars < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 4) != 0)
                build_nested_text($urandom_range(1, 24));
            else
                build_scrambled_text($urandom_range(1, 24));
            random_chars += text_q.size();
            send_text();
        end

        s_axis_tvalid <= 1'b0;

        // drain, then wait on to catch anything extra
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d characters in %0d texts, %0d results compared (%0d late marks).",
                 char_count, text_count, result_count, late_mark_count);
        $display("Texts covered unmatched closes, kinds left open and a gap-free stretch.");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d results still expected", pending_count);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
